// ===== rtl/lrb_pkg.sv =====
// Shared types, constants and reset values for the link reconnect backoff block.
`timescale 1ns / 1ps

package lrb_pkg;

	// Field widths of the event and result transactions
	localparam int CMD_W    = 3;
	localparam int TIME_W   = 48;
	localparam int DRAW_W   = 9;
	localparam int STATE_W  = 2;
	localparam int STAT_W   = 2;
	localparam int DELAY_W  = 17;
	localparam int COUNT_W  = 16;

	// Configuration port
	localparam int NUM_REGS = 6;
	localparam int REG_W    = 16;
	localparam int REGIDX_W = 3;

	// Backoff table depth; the attempt index saturates at its last entry
	localparam int STEPS    = 6;
	localparam int ATT_W    = 3;

	// Jitter arithmetic: delay = base * (800 + draw mod 401) / 1000
	localparam int FACT_W   = 11;
	localparam int PROD_W   = REG_W + FACT_W;
	localparam logic [DRAW_W-1:0] JITTER_MOD  = DRAW_W'(401);
	localparam logic [FACT_W-1:0] JITTER_BASE = FACT_W'(800);

	// Divide by 1000 as multiply by ceil(2^37 / 1000), exact for products below 2^27
	localparam int RECIP_W     = 28;
	localparam int RECIP_SHIFT = 37;
	localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(137438954);
	localparam int QPROD_W     = PROD_W + RECIP_W;

	localparam int DEADLINE_W = TIME_W + 1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Register indexes
	typedef enum logic [REGIDX_W-1:0] {
		REG_STEP0 = 3'd0,
		REG_STEP1 = 3'd1,
		REG_STEP2 = 3'd2,
		REG_STEP3 = 3'd3,
		REG_STEP4 = 3'd4,
		REG_CAP   = 3'd5
	} lrb_reg_t;

	typedef logic [REG_W-1:0] lrb_delay_tab_t [NUM_REGS];

	localparam lrb_delay_tab_t DELAY_RESET = '{
		16'd1000, 16'd2000, 16'd4000, 16'd8000, 16'd16000, 16'd30000
	};

	// Event commands
	typedef enum logic [CMD_W-1:0] {
		CMD_START      = 3'd0,
		CMD_STOP       = 3'd1,
		CMD_STA_START  = 3'd2,
		CMD_DISCONNECT = 3'd3,
		CMD_GOT_ADDR   = 3'd4,
		CMD_POLL       = 3'd5
	} lrb_cmd_t;

	// Link states
	typedef enum logic [STATE_W-1:0] {
		ST_STOPPED    = 2'd0,
		ST_CONNECTING = 2'd1,
		ST_CONNECTED  = 2'd2,
		ST_BACKOFF    = 2'd3
	} lrb_state_t;

	// Status codes for start and stop
	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_INV_STATE = 2'd1,
		STAT_INV_ARG   = 2'd2
	} lrb_status_t;

endpackage

// ===== rtl/lrb_if.sv =====
// Valid/ready channel interfaces for event and result transactions.
`timescale 1ns / 1ps

interface lrb_evt_if;
	logic                        valid;
	logic                        ready;
	logic [lrb_pkg::CMD_W-1:0]   command;
	logic [lrb_pkg::TIME_W-1:0]  now_ms;
	logic [lrb_pkg::DRAW_W-1:0]  jitter_draw;
	logic                        ssid_empty;

	modport source (output valid, command, now_ms, jitter_draw, ssid_empty, input ready);
	modport sink   (input valid, command, now_ms, jitter_draw, ssid_empty, output ready);
endinterface

interface lrb_res_if;
	logic                         valid;
	logic                         ready;
	logic [lrb_pkg::STATE_W-1:0]  link_state;
	logic                         connect_request;
	logic [lrb_pkg::STAT_W-1:0]   status;
	logic [lrb_pkg::DELAY_W-1:0]  retry_delay_ms;
	logic [lrb_pkg::COUNT_W-1:0]  disconnect_total;

	modport source (output valid, link_state, connect_request, status, retry_delay_ms,
		disconnect_total, input ready);
	modport sink   (input valid, link_state, connect_request, status, retry_delay_ms,
		disconnect_total, output ready);
endinterface

// ===== rtl/link_reconnect_backoff_top.sv =====
// Link reconnect controller with exponential backoff and jitter.
//
//  chan | dir | fields
//  evt  | in  | command, now_ms, jitter_draw, ssid_empty (valid/ready)
//  res  | out | link_state, connect_request, status, retry_delay_ms, disconnect_total
//  cfg  | in  | cfg_we, cfg_index, cfg_data
//
// One event per cycle while the result side takes results; an event goes through the input register,
// then jitter product, divide by 1000 and state update into the result register.
// The jitter product and the reciprocal multiply for the divide by 1000 share one stage.
// arst_n clears the valid flags and controller state and loads the table reset values at once.
// The input register keeps filling while a result waits, so the input stalls only when both
// the input and result registers hold transactions.
`timescale 1ns / 1ps

module link_reconnect_backoff_top (
	input  logic                           clk,
	input  logic                           arst_n,
	lrb_evt_if.sink                        evt,
	lrb_res_if.source                      res,
	input  logic                           cfg_we,
	input  logic [lrb_pkg::REGIDX_W-1:0]   cfg_index,
	input  logic [lrb_pkg::REG_W-1:0]      cfg_data
);

	// Delay table
	logic [lrb_pkg::REG_W-1:0] delay_q [lrb_pkg::NUM_REGS];

	// Stage 1: registered event
	logic                           v_s1;
	lrb_pkg::lrb_cmd_t              cmd_s1;
	logic [lrb_pkg::TIME_W-1:0]     now_s1;
	logic [lrb_pkg::DRAW_W-1:0]     draw_s1;
	logic                           ssid_s1;

	// Controller state
	logic [lrb_pkg::ATT_W-1:0]      attempt_q;
	lrb_pkg::lrb_state_t            conn_q;
	logic                           running_q;
	logic [lrb_pkg::COUNT_W-1:0]    disc_q;
	logic [lrb_pkg::TIME_W-1:0]     dl_base_q;
	logic [lrb_pkg::DELAY_W-1:0]    dl_off_q;

	// Result register
	logic                           out_v_q;
	lrb_pkg::lrb_state_t            out_state_q;
	logic                           out_req_q;
	lrb_pkg::lrb_status_t           out_stat_q;
	logic [lrb_pkg::DELAY_W-1:0]    out_delay_q;
	logic [lrb_pkg::COUNT_W-1:0]    out_disc_q;

	logic en_out, en_s1;
	logic fire_s1;

	logic [lrb_pkg::DRAW_W-1:0]     draw_mod;
	logic [lrb_pkg::FACT_W-1:0]     factor;
	logic [lrb_pkg::REG_W-1:0]      base_sel;
	logic [lrb_pkg::ATT_W-1:0]      step_idx;
	logic [lrb_pkg::PROD_W-1:0]     prod;

	logic [lrb_pkg::QPROD_W-1:0]    qprod;
	logic [lrb_pkg::DELAY_W-1:0]    quot;
	logic [lrb_pkg::DEADLINE_W-1:0] deadline;
	logic                           poll_due;

	lrb_pkg::lrb_state_t            conn_d;
	logic                           running_d;
	logic [lrb_pkg::COUNT_W-1:0]    disc_d;
	logic                           arm_deadline;
	lrb_pkg::lrb_status_t           stat_d;
	logic                           req_d;
	logic [lrb_pkg::DELAY_W-1:0]    delay_d;

	// Advance a stage when the next one is empty or moving
	assign en_out    = !out_v_q || res.ready;
	assign en_s1     = !v_s1 || en_out;
	assign evt.ready = en_s1;
	assign fire_s1   = v_s1 && en_out;

	// Write configuration registers; indexes past the table are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= lrb_pkg::DELAY_RESET;
		end else if (cfg_we && cfg_index <= lrb_pkg::REG_CAP) begin
			delay_q[cfg_index] <= cfg_data;
		end
	end

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && evt.valid) begin
			cmd_s1  <= lrb_pkg::lrb_cmd_t'(evt.command);
			now_s1  <= evt.now_ms;
			draw_s1 <= evt.jitter_draw;
			ssid_s1 <= evt.ssid_empty;
		end
	end

	// Reduce the draw, pick the table step and form the jitter product
	always_comb begin
		draw_mod = (draw_s1 >= lrb_pkg::JITTER_MOD) ? draw_s1 - lrb_pkg::JITTER_MOD : draw_s1;
		factor   = lrb_pkg::JITTER_BASE + lrb_pkg::FACT_W'(draw_mod);
		step_idx = (attempt_q > lrb_pkg::ATT_W'(lrb_pkg::STEPS - 1)) ?
			lrb_pkg::ATT_W'(lrb_pkg::STEPS - 1) : attempt_q;
		if (step_idx > lrb_pkg::ATT_W'(lrb_pkg::REG_CAP)) begin
			step_idx = lrb_pkg::ATT_W'(lrb_pkg::REG_CAP);
		end
		base_sel = delay_q[step_idx];
		prod     = lrb_pkg::PROD_W'(base_sel) * lrb_pkg::PROD_W'(factor);
	end

	// Track the attempt index as transactions leave stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_q <= '0;
		end else if (fire_s1) begin
			case (cmd_s1)
				lrb_pkg::CMD_DISCONNECT: begin
					if (attempt_q < lrb_pkg::ATT_W'(lrb_pkg::STEPS - 1)) begin
						attempt_q <= attempt_q + 1'b1;
					end
				end
				lrb_pkg::CMD_GOT_ADDR: begin
					attempt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Divide by 1000 and check the armed deadline
	always_comb begin
		qprod    = lrb_pkg::QPROD_W'(prod) * lrb_pkg::QPROD_W'(lrb_pkg::RECIP_1000);
		quot     = qprod[lrb_pkg::RECIP_SHIFT +: lrb_pkg::DELAY_W];
		deadline = lrb_pkg::DEADLINE_W'(dl_base_q) + lrb_pkg::DEADLINE_W'(dl_off_q);
		poll_due = lrb_pkg::DEADLINE_W'(now_s1) >= deadline;
	end

	// Next controller state
	always_comb begin
		conn_d       = conn_q;
		running_d    = running_q;
		disc_d       = disc_q;
		arm_deadline = 1'b0;
		case (cmd_s1)
			lrb_pkg::CMD_START: begin
				if (!running_q && !ssid_s1) begin
					running_d = 1'b1;
				end
			end
			lrb_pkg::CMD_STOP: begin
				if (running_q) begin
					running_d = 1'b0;
					conn_d    = lrb_pkg::ST_STOPPED;
				end
			end
			lrb_pkg::CMD_STA_START: begin
				conn_d = lrb_pkg::ST_CONNECTING;
			end
			lrb_pkg::CMD_DISCONNECT: begin
				if (disc_q != lrb_pkg::COUNT_MAX) begin
					disc_d = disc_q + 1'b1;
				end
				arm_deadline = 1'b1;
				conn_d       = lrb_pkg::ST_BACKOFF;
			end
			lrb_pkg::CMD_GOT_ADDR: begin
				conn_d = lrb_pkg::ST_CONNECTED;
			end
			lrb_pkg::CMD_POLL: begin
				if (running_q && conn_q == lrb_pkg::ST_BACKOFF && poll_due) begin
					conn_d = lrb_pkg::ST_CONNECTING;
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields
	always_comb begin
		stat_d  = lrb_pkg::STAT_OK;
		req_d   = 1'b0;
		delay_d = '0;
		case (cmd_s1)
			lrb_pkg::CMD_START: begin
				if (running_q) begin
					stat_d = lrb_pkg::STAT_INV_STATE;
				end else if (ssid_s1) begin
					stat_d = lrb_pkg::STAT_INV_ARG;
				end
			end
			lrb_pkg::CMD_STOP: begin
				if (!running_q) begin
					stat_d = lrb_pkg::STAT_INV_STATE;
				end
			end
			lrb_pkg::CMD_STA_START: begin
				req_d = 1'b1;
			end
			lrb_pkg::CMD_DISCONNECT: begin
				delay_d = quot;
			end
			lrb_pkg::CMD_POLL: begin
				req_d = running_q && conn_q == lrb_pkg::ST_BACKOFF && poll_due;
			end
			default: begin
			end
		endcase
	end

	// Commit state as the transaction moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_q    <= lrb_pkg::ST_STOPPED;
			running_q <= 1'b0;
			disc_q    <= '0;
			dl_base_q <= '0;
			dl_off_q  <= '0;
		end else if (fire_s1) begin
			conn_q    <= conn_d;
			running_q <= running_d;
			disc_q    <= disc_d;
			if (arm_deadline) begin
				dl_base_q <= now_s1;
				dl_off_q  <= quot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_state_q <= conn_d;
			out_req_q   <= req_d;
			out_stat_q  <= stat_d;
			out_delay_q <= delay_d;
			out_disc_q  <= disc_d;
		end
	end

	assign res.valid            = out_v_q;
	assign res.link_state       = out_state_q;
	assign res.connect_request  = out_req_q;
	assign res.status           = out_stat_q;
	assign res.retry_delay_ms   = out_delay_q;
	assign res.disconnect_total = out_disc_q;

`ifndef SYNTH
	// Attempt index never runs past the last table step
	a_attempt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		attempt_q <= lrb_pkg::ATT_W'(lrb_pkg::STEPS - 1))
		else $error("attempt index beyond last step");

	// A connect request always leaves the link connecting
	a_req_state: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.connect_request) |-> res.link_state == lrb_pkg::ST_CONNECTING)
		else $error("connect request without connecting state");

	// A nonzero retry delay only comes with backoff
	a_delay_state: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.retry_delay_ms != '0) |-> res.link_state == lrb_pkg::ST_BACKOFF)
		else $error("retry delay outside backoff");

	// Disconnect count only moves up, one at a time
	a_disc_mono: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q != $past(disc_q) |-> disc_q == $past(disc_q) + 1'b1)
		else $error("disconnect count jumped");

	// A stop while running leaves the link stopped and the controller not running
	a_stop_run: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && cmd_s1 == lrb_pkg::CMD_STOP && running_q |=> conn_q == lrb_pkg::ST_STOPPED
		&& !running_q)
		else $error("stop did not halt the controller");
`endif

endmodule
